>>> rtl/ffls_pkg.sv
// ----------------------------------------------------------------------------
// ffls_pkg
// Types and constants shared by the FASTA/FASTQ length scanner modules.
// ----------------------------------------------------------------------------
package ffls_pkg;

   localparam int DATA_BITS   = 8;
   localparam int TOTAL_BITS  = 48;
   localparam int MAX_BITS    = 32;
   localparam int STATUS_BITS = 2;

   localparam logic [DATA_BITS-1:0] CHAR_GT    = 8'h3E;  // '>'
   localparam logic [DATA_BITS-1:0] CHAR_AT    = 8'h40;  // '@'
   localparam logic [DATA_BITS-1:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [DATA_BITS-1:0] CHAR_NL    = 8'h0A;  // '\n'
   localparam logic [DATA_BITS-1:0] CHAR_SPACE = 8'h20;  // ' '

   typedef enum logic [2:0] {
      PHASE_MARK = 3'd0,
      PHASE_HEAD = 3'd1,
      PHASE_SEQ  = 3'd2,
      PHASE_PLUS = 3'd3,
      PHASE_QUAL = 3'd4,
      PHASE_ERR  = 3'd5
   } phase_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_MARKER  = 2'd1,
      STATUS_TRUNC_QUAL = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] data_byte;
      logic                 end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0]  total_length;
      logic [MAX_BITS-1:0]    max_length;
      logic [STATUS_BITS-1:0] status;
   } rsp_word_type;

   // handshake between input register and parser
   typedef struct packed {
      logic valid;
      logic take;
   } in_ctrl_type;

endpackage

>>> rtl/fasta_fastq_length_scanner.sv
// Result path: end-of-stream word in input register, parser, output register.
// Throughput unless stalled: one byte word per cycle, from input register to parser.
// An end-of-stream word waits in the input register while an earlier result is stalled.
// Reset (synchronous, active high) clears parse state, totals and both valid flags.
// ----------------------------------------------------------------------------
// fasta_fastq_length_scanner
// Measures FASTA/FASTQ record lengths from a byte stream; reports total,
// maximum and status at end of stream.
// ----------------------------------------------------------------------------
module fasta_fastq_length_scanner #(
   parameter int RECORD_LEN_BITS = 32,
   parameter int TOTAL_LEN_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffls_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffls_pkg::rsp_word_type rsp_word
);
   import ffls_pkg::*;

   in_ctrl_type  in_ctrl;
   req_word_type item;
   logic         take;
   logic         rsp_free;
   logic         result_valid;
   rsp_word_type result;

   ffls_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .take      (take),
      .ctrl      (in_ctrl),
      .item      (item)
   );

   ffls_parser #(
      .RECORD_LEN_BITS (RECORD_LEN_BITS),
      .TOTAL_LEN_BITS  (TOTAL_LEN_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (in_ctrl),
      .item         (item),
      .rsp_free     (rsp_free),
      .take         (take),
      .result_valid (result_valid),
      .result       (result)
   );

   ffls_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .result    (result),
      .rsp_free  (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

>>> rtl/ffls_in_stage.sv
// ----------------------------------------------------------------------------
// ffls_in_stage
// Input register: captures one request word and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module ffls_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ffls_pkg::req_word_type req_word,
   input  logic                  take,
   output ffls_pkg::in_ctrl_type ctrl,
   output ffls_pkg::req_word_type item
);
   import ffls_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff, word_in;
   logic         accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (accept) begin
         valid_in = 1'b1;
         word_in  = req_word;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign ctrl.valid = valid_ff;
   assign ctrl.take  = take;
   assign item       = word_ff;

endmodule

>>> rtl/ffls_parser.sv
// ----------------------------------------------------------------------------
// ffls_parser
// Record parser: phase, letter count, saturating total and maximum. Makes
// one step per word and builds the summary on end of stream.
// ----------------------------------------------------------------------------
module ffls_parser #(
   parameter int RECORD_LEN_BITS = 32,
   parameter int TOTAL_LEN_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffls_pkg::in_ctrl_type  ctrl,
   input  ffls_pkg::req_word_type item,
   input  logic                   rsp_free,
   output logic                   take,
   output logic                   result_valid,
   output ffls_pkg::rsp_word_type result
);
   import ffls_pkg::*;

   localparam int SUM_W = ((RECORD_LEN_BITS > TOTAL_LEN_BITS) ?
                           RECORD_LEN_BITS : TOTAL_LEN_BITS) + 1;
   localparam logic [RECORD_LEN_BITS-1:0] REC_MAX = '1;
   localparam logic [SUM_W-1:0] TOT_MAX = SUM_W'({TOTAL_LEN_BITS{1'b1}});

   phase_type                  phase_ff, phase_in;
   logic                       fmt_ff, fmt_in;       // 1 = FASTQ
   logic [RECORD_LEN_BITS-1:0] cnt_ff, cnt_in;
   logic [TOTAL_LEN_BITS-1:0]  total_ff, total_in;
   logic [RECORD_LEN_BITS-1:0] max_ff, max_in;
   status_type                 err_ff, err_in;

   logic [SUM_W-1:0]           sum;
   logic [TOTAL_LEN_BITS-1:0]  closed_total;
   logic [RECORD_LEN_BITS-1:0] closed_max;
   logic [TOTAL_LEN_BITS-1:0]  fin_total;
   logic [RECORD_LEN_BITS-1:0] fin_max;
   status_type                 fin_err;
   logic [63:0]                total_wide;
   logic [63:0]                max_wide;
   logic                       ws;
   logic                       cnt_zero;

   assign take     = ctrl.valid && (!item.end_of_stream || rsp_free);
   assign ws       = item.data_byte <= CHAR_SPACE;
   assign cnt_zero = cnt_ff == '0;

   // record close: saturating add into total, fold into max
   assign sum          = SUM_W'(total_ff) + SUM_W'(cnt_ff);
   assign closed_total = (sum > TOT_MAX) ? TOT_MAX[TOTAL_LEN_BITS-1:0]
                                         : sum[TOTAL_LEN_BITS-1:0];
   assign closed_max   = (cnt_ff > max_ff) ? cnt_ff : max_ff;

   always_comb begin
      phase_in     = phase_ff;
      fmt_in       = fmt_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      max_in       = max_ff;
      err_in       = err_ff;
      fin_total    = total_ff;
      fin_max      = max_ff;
      fin_err      = err_ff;
      result_valid = 1'b0;
      if (take) begin
         if (item.end_of_stream) begin
            case (phase_ff)
               PHASE_SEQ: begin
                  fin_total = closed_total;
                  fin_max   = closed_max;
                  if (fmt_ff && !cnt_zero) begin
                     fin_err = STATUS_TRUNC_QUAL;
                  end
               end
               PHASE_PLUS, PHASE_QUAL: begin
                  if (!cnt_zero) begin
                     fin_err = STATUS_TRUNC_QUAL;
                  end
               end
               default: ;
            endcase
            result_valid = 1'b1;
            phase_in     = PHASE_MARK;
            fmt_in       = 1'b0;
            cnt_in       = '0;
            total_in     = '0;
            max_in       = '0;
            err_in       = STATUS_OK;
         end else begin
            case (phase_ff)
               PHASE_MARK: begin
                  if (!ws) begin
                     if (item.data_byte == CHAR_GT || item.data_byte == CHAR_AT) begin
                        fmt_in   = item.data_byte == CHAR_AT;
                        phase_in = PHASE_HEAD;
                     end else begin
                        err_in   = STATUS_NO_MARKER;
                        phase_in = PHASE_ERR;
                     end
                  end
               end
               PHASE_HEAD: begin
                  if (item.data_byte == CHAR_NL) begin
                     cnt_in   = '0;
                     phase_in = PHASE_SEQ;
                  end
               end
               PHASE_SEQ: begin
                  if (!fmt_ff && item.data_byte == CHAR_GT) begin
                     // '>' closes this record and opens the next header
                     total_in = closed_total;
                     max_in   = closed_max;
                     cnt_in   = '0;
                     phase_in = PHASE_HEAD;
                  end else if (fmt_ff && item.data_byte == CHAR_PLUS) begin
                     total_in = closed_total;
                     max_in   = closed_max;
                     phase_in = PHASE_PLUS;
                  end else if (!ws && cnt_ff != REC_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               PHASE_PLUS: begin
                  if (item.data_byte == CHAR_NL) begin
                     phase_in = cnt_zero ? PHASE_MARK : PHASE_QUAL;
                  end
               end
               PHASE_QUAL: begin
                  if (!ws && !cnt_zero) begin
                     cnt_in = cnt_ff - 1'b1;
                     if (cnt_ff == RECORD_LEN_BITS'(1)) begin
                        phase_in = PHASE_MARK;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_MARK;
         fmt_ff   <= 1'b0;
         cnt_ff   <= '0;
         total_ff <= '0;
         max_ff   <= '0;
         err_ff   <= STATUS_OK;
      end else begin
         phase_ff <= phase_in;
         fmt_ff   <= fmt_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         max_ff   <= max_in;
         err_ff   <= err_in;
      end
   end

   assign total_wide          = 64'(fin_total);
   assign max_wide            = 64'(fin_max);
   assign result.total_length = total_wide[TOTAL_BITS-1:0];
   assign result.max_length   = max_wide[MAX_BITS-1:0];
   assign result.status       = fin_err;

   // end of stream puts everything back to the reset state
   a_eos_clears : assert property (@(posedge clock) disable iff (reset)
      take && item.end_of_stream |=>
         phase_ff == PHASE_MARK && cnt_ff == '0 && total_ff == '0 && max_ff == '0)
      else $error("state not cleared after end of stream");

   // error phase is sticky until end of stream
   a_err_sticky : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_ERR && !(take && item.end_of_stream) |=> phase_ff == PHASE_ERR)
      else $error("left error phase without end of stream");

   // error phase always carries a nonzero status
   a_err_code : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_ERR |-> err_ff != STATUS_OK)
      else $error("error phase with ok status");

   // an end-of-stream word is only taken when the result slot can hold it
   a_eos_room : assert property (@(posedge clock) disable iff (reset)
      take && item.end_of_stream |-> rsp_free)
      else $error("end of stream taken with result slot busy");

endmodule

>>> rtl/ffls_out_stage.sv
// ----------------------------------------------------------------------------
// ffls_out_stage
// Result register: holds the summary word until the consumer takes it.
// ----------------------------------------------------------------------------
module ffls_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ffls_pkg::rsp_word_type result,
   output logic                   rsp_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffls_pkg::rsp_word_type rsp_word
);
   import ffls_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   assign rsp_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = result;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
